[rtl/core/fasb_pkg.sv]
// fasb_pkg: shared types and constants for the flow aggregation shadow buffer
// used by fasb_ctrl, fasb_dpath and flow_aggregation_shadow_buffer_top
package fasb_pkg;

   localparam int SLOTS_DEFAULT = 8;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  proto;
      logic [15:0] pkt_increment;
      logic [15:0] byte_increment;
   } req_type;

   typedef struct packed {
      logic [31:0] out_src_ip;
      logic [31:0] out_dst_ip;
      logic [15:0] out_src_port;
      logic [15:0] out_dst_port;
      logic [7:0]  out_proto;
      logic [31:0] pkt_total;
      logic [31:0] byte_total;
      logic        last_of_flush;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  proto;
   } flow_key_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic apply_hit;
      logic apply_insert;
      logic emit;
      logic reload;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic full;
      logic emit_done;
   } status_type;

endpackage

[rtl/core/fasb_ctrl.sv]
// fasb_ctrl: sequencer for lookup, update and flush of the shadow buffer
// depends on fasb_pkg; drives fasb_dpath through cmd_type, reads status_type
module fasb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fasb_pkg::status_type status,
   output fasb_pkg::cmd_type    cmd
);
   import fasb_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      flush_pending;

   assign flush_pending = !status.hit && status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (flush_pending) state_in = ST_FLUSH;
            else if (start) state_in = ST_LOOKUP;
            else state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (status.emit_done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_UPDATE: begin
            busy             = flush_pending;
            cmd.capture      = start && !flush_pending;
            cmd.apply_hit    = status.hit;
            cmd.apply_insert = !status.hit && !status.full;
         end
         ST_FLUSH: begin
            cmd.emit   = 1'b1;
            cmd.reload = status.emit_done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[rtl/core/fasb_dpath.sv]
// fasb_dpath: slot registers, parallel key compare, counters and flush output
// depends on fasb_pkg; commanded by fasb_ctrl
module fasb_dpath #(
   parameter int SLOTS = fasb_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fasb_pkg::cmd_type    cmd,
   output fasb_pkg::status_type status,
   input  fasb_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output fasb_pkg::rsp_type    rsp_data
);
   import fasb_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   req_type           req_ff, req_in;
   flow_key_type      req_key;
   flow_key_type      key_ff [SLOTS];
   flow_key_type      key_in [SLOTS];
   logic [31:0]       pkt_ff [SLOTS];
   logic [31:0]       pkt_in [SLOTS];
   logic [31:0]       byte_ff [SLOTS];
   logic [31:0]       byte_in [SLOTS];
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SLOTS-1:0]  match_ff, match_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              emit_done;

   assign req_key = '{src_ip:   req_ff.src_ip,
                      dst_ip:   req_ff.dst_ip,
                      src_port: req_ff.src_port,
                      dst_port: req_ff.dst_port,
                      proto:    req_ff.proto};

   assign emit_done     = (cnt_ff == IDX_W'(SLOTS - 1));
   assign status.hit    = |match_ff;
   assign status.full   = (used_ff == CNT_W'(SLOTS));
   assign status.emit_done = emit_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // request latch and one compare per used slot
   always_comb begin
      req_in   = cmd.capture ? req_data : req_ff;
      match_in = match_ff;
      if (cmd.lookup) begin
         for (int i = 0; i < SLOTS; i++) begin
            match_in[i] = (used_ff > CNT_W'(i)) && (key_ff[i] == req_key);
         end
      end
   end

   // slot contents and fill count
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         key_in[i]  = key_ff[i];
         pkt_in[i]  = pkt_ff[i];
         byte_in[i] = byte_ff[i];
         if (cmd.apply_hit && match_ff[i]) begin
            pkt_in[i]  = pkt_ff[i] + 32'(req_ff.pkt_increment);
            byte_in[i] = byte_ff[i] + 32'(req_ff.byte_increment);
         end
      end
      used_in = used_ff;
      if (cmd.apply_insert) begin
         key_in[used_ff[IDX_W-1:0]]  = req_key;
         pkt_in[used_ff[IDX_W-1:0]]  = 32'(req_ff.pkt_increment);
         byte_in[used_ff[IDX_W-1:0]] = 32'(req_ff.byte_increment);
         used_in = used_ff + CNT_W'(1);
      end
      if (cmd.reload) begin
         key_in[0]  = req_key;
         pkt_in[0]  = 32'(req_ff.pkt_increment);
         byte_in[0] = 32'(req_ff.byte_increment);
         used_in    = CNT_W'(1);
      end
   end

   // flush readout
   always_comb begin
      cnt_in       = cmd.emit ? cnt_ff + IDX_W'(1) : '0;
      rsp_valid_in = cmd.emit;
      rsp_in       = rsp_ff;
      if (cmd.emit) begin
         rsp_in.out_src_ip    = key_ff[cnt_ff].src_ip;
         rsp_in.out_dst_ip    = key_ff[cnt_ff].dst_ip;
         rsp_in.out_src_port  = key_ff[cnt_ff].src_port;
         rsp_in.out_dst_port  = key_ff[cnt_ff].dst_port;
         rsp_in.out_proto     = key_ff[cnt_ff].proto;
         rsp_in.pkt_total     = pkt_ff[cnt_ff];
         rsp_in.byte_total    = byte_ff[cnt_ff];
         rsp_in.last_of_flush = emit_done;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i]  <= '0;
            pkt_ff[i]  <= '0;
            byte_ff[i] <= '0;
         end
         used_ff      <= CNT_W'(1);
         match_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i]  <= key_in[i];
            pkt_ff[i]  <= pkt_in[i];
            byte_ff[i] <= byte_in[i];
         end
         used_ff      <= used_in;
         match_ff     <= match_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("more than one slot matched");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) && (used_ff <= CNT_W'(SLOTS)))
      else $error("fill count out of range");

   a_reload_count: assert property (@(posedge clock) disable iff (reset)
      cmd.reload |=> (used_ff == CNT_W'(1)))
      else $error("fill count not one after flush");

   a_flush_full: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.full)
      else $error("flush while buffer not full");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && emit_done |=> rsp_valid_ff && rsp_ff.last_of_flush)
      else $error("last item of flush not flagged");

endmodule

[rtl/core/flow_aggregation_shadow_buffer_top.sv]
// flow_aggregation_shadow_buffer_top: per-flow packet and byte counting buffer
// depends on fasb_pkg, fasb_ctrl and fasb_dpath
//
// A packet is taken when start is high and busy is low. A hit or an insert
// into a free slot passes through LOOKUP, the parallel key compare, then
// UPDATE, the counter add or slot load; the next packet can be taken in
// UPDATE but not in LOOKUP. A miss on a full buffer flushes every slot in
// slot order, one item per cycle on rsp_valid/rsp_data with last_of_flush
// on the final one; that packet then reloads slot 0, and no packet is taken
// until the flush ends. There is no back pressure on the result side: each
// item shows for one cycle and must be captured then.
module flow_aggregation_shadow_buffer_top #(
   parameter int SLOTS = fasb_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fasb_pkg::req_type req_data,
   output logic              rsp_valid,
   output fasb_pkg::rsp_type rsp_data
);
   import fasb_pkg::*;

   cmd_type    cmd;
   status_type status;

   fasb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   fasb_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_flow_aggregation_shadow_buffer_top.sv]
// tb_flow_aggregation_shadow_buffer_top: self-checking bench for the flow aggregation buffer
// drives packets, tracks per-flow hit/insert/flush behavior and checks every flushed item
// depends on fasb_pkg and flow_aggregation_shadow_buffer_top
module tb_flow_aggregation_shadow_buffer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fasb_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int REPEAT_HITS = 12;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   flow_key_type flow_keys[SLOTS];
   logic [31:0]  pkt_totals[SLOTS];
   logic [31:0]  byte_totals[SLOTS];
   int           slots_in_use;
   rsp_type      flush_expect_q[$];
   int           mismatches = 0;
   int unsigned  cycle_count = 0;
   flow_key_type seed_keys[SLOTS-1];
   flow_key_type trigger_key;

   flow_aggregation_shadow_buffer_top #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void account_packet(req_type p);
      flow_key_type k;
      int           hit_slot;
      rsp_type      r;
      k = '{p.src_ip, p.dst_ip, p.src_port, p.dst_port, p.proto};
      hit_slot = -1;
      for (int s = 0; s < slots_in_use; s++)
         if (hit_slot < 0 && flow_keys[s] == k)
            hit_slot = s;
      if (hit_slot >= 0) begin
         pkt_totals[hit_slot]  = pkt_totals[hit_slot] + p.pkt_increment;
         byte_totals[hit_slot] = byte_totals[hit_slot] + p.byte_increment;
      end else if (slots_in_use < SLOTS) begin
         flow_keys[slots_in_use]   = k;
         pkt_totals[slots_in_use]  = p.pkt_increment;
         byte_totals[slots_in_use] = p.byte_increment;
         slots_in_use++;
      end else begin
         for (int s = 0; s < SLOTS; s++) begin
            r = '{flow_keys[s].src_ip, flow_keys[s].dst_ip, flow_keys[s].src_port,
                  flow_keys[s].dst_port, flow_keys[s].proto, pkt_totals[s],
                  byte_totals[s], (s == SLOTS - 1)};
            flush_expect_q.push_back(r);
         end
         flow_keys[0]   = k;
         pkt_totals[0]  = p.pkt_increment;
         byte_totals[0] = p.byte_increment;
         slots_in_use = 1;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : flush_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (flush_expect_q.size() == 0) begin
            $error("flush item with nothing expected: %h", rsp_data);
            mismatches++;
         end else begin
            want = flush_expect_q.pop_front();
            check_field("out_src_ip", want.out_src_ip, rsp_data.out_src_ip);
            check_field("out_dst_ip", want.out_dst_ip, rsp_data.out_dst_ip);
            check_field("out_src_port", want.out_src_port, rsp_data.out_src_port);
            check_field("out_dst_port", want.out_dst_port, rsp_data.out_dst_port);
            check_field("out_proto", want.out_proto, rsp_data.out_proto);
            check_field("pkt_total", want.pkt_total, rsp_data.pkt_total);
            check_field("byte_total", want.byte_total, rsp_data.byte_total);
            check_field("last_of_flush", want.last_of_flush, rsp_data.last_of_flush);
         end
      end
   end

   function automatic flow_key_type random_key();
      flow_key_type k;
      k = '{$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
      return k;
   endfunction

   function automatic logic [15:0] random_increment();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_packet(flow_key_type k, logic [15:0] pk, logic [15:0] by);
      req_type p;
      p = '{k.src_ip, k.dst_ip, k.src_port, k.dst_port, k.proto, pk, by};
      return p;
   endfunction

   task automatic send_packet(req_type p);
      req_data <= p;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      account_packet(p);
   endtask

   task automatic hold_off(int cycles);
      start    <= 1'b0;
      req_data <= make_packet(random_key(), 16'($urandom), 16'($urandom));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (flush_expect_q.size() != 0);
   endtask

   // zero key hits the slot that is in use after reset
   task automatic test_reset_slot();
      send_packet(make_packet('0, 16'h0001, 16'h0040));
      send_packet(make_packet('0, 16'hFFFF, 16'hFFFF));
   endtask

   task automatic test_fill_and_flush();
      seed_keys[0] = '1;
      seed_keys[1] = {13{8'hAA}};
      seed_keys[2] = {13{8'h55}};
      for (int i = 3; i < SLOTS - 1; i++)
         seed_keys[i] = random_key();
      foreach (seed_keys[i])
         send_packet(make_packet(seed_keys[i], (i == 0) ? 16'hFFFF : random_increment(),
                                 (i == 0) ? 16'hFFFF : random_increment()));
      hold_off(3);
      send_packet(make_packet(seed_keys[0], 16'h0000, 16'h0000));
      send_packet(make_packet(seed_keys[1], 16'h8000, 16'h0001));
      trigger_key = random_key();
      send_packet(make_packet(trigger_key, random_increment(), random_increment()));
   endtask

   // old entries above the used count must not match
   task automatic test_stale_slots();
      flow_key_type k;
      send_packet(make_packet(seed_keys[3], random_increment(), random_increment()));
      send_packet(make_packet(seed_keys[SLOTS-2], random_increment(), random_increment()));
      for (int i = 3; i < SLOTS; i++)
         send_packet(make_packet(random_key(), random_increment(), random_increment()));
      k = random_key();
      send_packet(make_packet(k, random_increment(), random_increment()));
      trigger_key = k;
   endtask

   task automatic test_repeated_hits();
      req_type p;
      p = make_packet(trigger_key, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < REPEAT_HITS; i++)
         send_packet(p);
      for (int i = 0; i < SLOTS; i++)
         send_packet(make_packet(random_key(), random_increment(), random_increment()));
   endtask

   task automatic test_random_traffic(int item_count);
      flow_key_type flow_pool[12];
      int           sent;
      int           burst_len;
      req_type      p;
      foreach (flow_pool[i])
         flow_pool[i] = random_key();
      flow_pool[0] = '0;
      flow_pool[1] = '1;
      sent = 0;
      while (sent < item_count) begin
         burst_len = $urandom_range(1, 12);
         for (int b = 0; b < burst_len && sent < item_count; b++) begin
            if ($urandom_range(0, 19) == 0)
               flow_pool[$urandom_range(0, 11)] = random_key();
            if ($urandom_range(0, 6) == 0)
               p = make_packet(random_key(), random_increment(), random_increment());
            else
               p = make_packet(flow_pool[$urandom_range(0, 11)], random_increment(),
                               random_increment());
            send_packet(p);
            sent++;
            if (sent == item_count / 2)
               wait_drained();
         end
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 14));
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      for (int s = 0; s < SLOTS; s++) begin
         flow_keys[s]   = '0;
         pkt_totals[s]  = '0;
         byte_totals[s] = '0;
      end
      slots_in_use = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_slot();
      test_fill_and_flush();
      test_stale_slots();
      test_repeated_hits();
      test_random_traffic(190);

      wait_drained();
      repeat (SLOTS + 8) @(posedge clock);
      if (mismatches == 0 && flush_expect_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
